[rtl/was_pkg.sv]
package was_pkg;

  // activation field, Q0.16 fraction
  localparam int unsigned ActBits = 16;
  // action field of a result word
  localparam int unsigned ActionW = 4;

  // minimal-standard generator x' = x * 48271 mod (2^31 - 1)
  localparam int unsigned RngW = 31;
  localparam int unsigned LcgMulW = 16;
  localparam logic [LcgMulW-1:0] LcgMul = 16'd48271;
  localparam logic [RngW-1:0] LcgMod = 31'h7FFF_FFFF;

  // action count range tops out at 64
  localparam int unsigned DefMaxActions = 16;
  localparam int unsigned MaxIdxW = 6;
  localparam int unsigned MaxCntW = 7;

  // configuration port
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 31;
  localparam logic [CfgIdxW-1:0] CfgUseMax = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSeed = 1'd1;

  typedef enum logic [2:0] {
    StAcc,
    StSel,
    StRed,
    StMul,
    StWalk,
    StFin
  } was_state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [MaxIdxW-1:0] pos;
    logic [MaxIdxW-1:0] sel;
  } was_token_t;

  // generator control
  typedef struct packed {
    logic load;
    logic mul;
    logic red;
  } was_lcg_ctrl_t;

endpackage

[rtl/was_ifs.sv]
interface was_in_if;
  logic                            valid;
  logic                            ready;
  logic [was_pkg::ActBits-1:0]     activation;
  logic                            last;

  modport source (output valid, activation, last, input ready);
  modport sink (input valid, activation, last, output ready);
endinterface

interface was_out_if;
  logic                            valid;
  logic                            ready;
  logic [was_pkg::ActionW-1:0]     action;

  modport source (output valid, action, input ready);
  modport sink (input valid, action, output ready);
endinterface

[rtl/was_lcg.sv]
module was_lcg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  was_pkg::was_lcg_ctrl_t    ctrl_i,
  input  logic [was_pkg::RngW-1:0]  seed_i,
  output logic [was_pkg::RngW-1:0]  state_o
);

  localparam int unsigned ProdW = was_pkg::RngW + was_pkg::LcgMulW;

  logic [was_pkg::RngW-1:0] state_q, state_d;
  logic [ProdW-1:0]         prod_q;
  logic [was_pkg::RngW:0]   fold;
  logic [was_pkg::RngW:0]   fold_red;
  logic [was_pkg::RngW-1:0] seed_state;

  // mersenne fold: high part added back onto the low part, one subtract at most
  assign fold = {1'b0, prod_q[was_pkg::RngW-1:0]}
              + (was_pkg::RngW + 1)'(prod_q[ProdW-1:was_pkg::RngW]);
  assign fold_red = (fold >= {1'b0, was_pkg::LcgMod}) ? fold - {1'b0, was_pkg::LcgMod}
                                                       : fold;

  assign seed_state = (seed_i == '0 || seed_i == was_pkg::LcgMod)
                    ? was_pkg::RngW'(1) : seed_i;

  always_comb begin
    state_d = state_q;
    if (ctrl_i.load) begin
      state_d = seed_state;
    end else if (ctrl_i.red) begin
      state_d = (fold_red == '0) ? was_pkg::RngW'(1) : fold_red[was_pkg::RngW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= ProdW'(state_q) * ProdW'(was_pkg::LcgMul);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= was_pkg::RngW'(1);
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[rtl/was_cell.sv]
module was_cell #(
  parameter int unsigned SumW = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [SumW-1:0]                     wr_data_i,
  input  logic [SumW+was_pkg::RngW-1:0]       rhs_i,
  input  logic [was_pkg::MaxCntW-1:0]         count_i,
  input  was_pkg::was_token_t                 tok_i,
  output was_pkg::was_token_t                 tok_o
);

  logic [SumW-1:0]     prefix_q;
  was_pkg::was_token_t tok_q, tok_d;
  logic                live;
  logic                hit;

  // entry exists in this set and its scaled prefix reaches the threshold
  assign live = {1'b0, tok_i.pos} < count_i;
  assign hit  = {prefix_q, {was_pkg::RngW{1'b0}}} >= rhs_i;

  always_comb begin
    tok_d     = tok_i;
    tok_d.pos = tok_i.pos + 1'b1;
    if (tok_i.valid && !tok_i.found && live && hit) begin
      tok_d.found = 1'b1;
      tok_d.sel   = tok_i.pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prefix_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[rtl/weighted_action_selector.sv]
// weighted action selector: roulette-wheel pick over one set of activations
// in_if carries one activation word (unsigned Q0.16) and a last flag; out_if
// carries one action word per set, given after the word flagged last.
// a non-last word is taken on its handshake: it adds to the running sum, stores
// its prefix sum in the next cell of the chain and updates the running max.
// words beyond MAX_ACTIONS in a set are dropped, their last flag still counts.
// after a last word, max mode goes from the select state to the final state;
// sampling mode steps the generator (multiply, fold), forms the threshold
// multiply and walks the search token along the cell chain one cell per cycle.
// a zero sum skips the walk.
// in_if.ready is low during that time; the action lands in an output register
// and the next set may start while it waits on a stalled receiver. a second
// result waits in the final state until the output register frees.
// cfg write index 0 sets use_max, index 1 loads the generator from the seed.
// reset empties the set, clears use_max and puts the generator at one.
module weighted_action_selector #(
  parameter int unsigned MAX_ACTIONS = was_pkg::DefMaxActions
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  was_in_if.sink                        in_if,
  was_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [was_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [was_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ACTIONS + 1);
  localparam int unsigned SumW = was_pkg::ActBits + IdxW;
  localparam int unsigned RhsW = SumW + was_pkg::RngW;
  localparam int unsigned ZprW = was_pkg::RngW + CntW;

  // fsm
  was_pkg::was_state_e state_q, state_d;

  // set state
  logic [SumW-1:0]             sum_q;
  logic [CntW-1:0]             count_q;
  logic [was_pkg::ActBits-1:0] best_val_q;
  logic [IdxW-1:0]             best_idx_q;
  logic                        use_max_q;

  // selection datapath
  logic [RhsW-1:0]             rhs_q;
  logic [IdxW-1:0]             res_q;
  logic                        launch_q, launch_d;
  logic                        out_valid_q;
  logic [was_pkg::ActionW-1:0] out_action_q;

  // control
  logic                        in_acc;
  logic                        acc_wr;
  logic                        out_free;
  logic                        fin_go;
  logic                        sum_zero;
  was_pkg::was_lcg_ctrl_t      lcg_ctrl;
  logic [was_pkg::RngW-1:0]    rng;
  logic [was_pkg::RngW-1:0]    draw;
  logic [ZprW-1:0]             zprod;
  logic [SumW-1:0]             sum_next;
  logic [MAX_ACTIONS-1:0]      wr_en;

  was_pkg::was_token_t         tok [MAX_ACTIONS+1];

  assign in_acc   = in_if.valid && in_if.ready;
  assign acc_wr   = in_acc && (count_q < CntW'(MAX_ACTIONS));
  assign out_free = !out_valid_q || out_if.ready;
  assign sum_zero = (sum_q == '0);
  assign sum_next = sum_q + SumW'(in_if.activation);
  assign draw     = rng - was_pkg::RngW'(1);
  assign zprod    = ZprW'(draw) * ZprW'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      was_pkg::StAcc: begin
        if (in_acc && in_if.last) state_d = was_pkg::StSel;
      end
      was_pkg::StSel: begin
        state_d = use_max_q ? was_pkg::StFin : was_pkg::StRed;
      end
      was_pkg::StRed: begin
        state_d = was_pkg::StMul;
      end
      was_pkg::StMul: begin
        state_d = sum_zero ? was_pkg::StFin : was_pkg::StWalk;
      end
      was_pkg::StWalk: begin
        if (tok[MAX_ACTIONS].valid) state_d = was_pkg::StFin;
      end
      was_pkg::StFin: begin
        if (out_free) state_d = was_pkg::StAcc;
      end
      default: begin
        state_d = was_pkg::StAcc;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_if.ready   = 1'b0;
    lcg_ctrl.load = cfg_we_i && (cfg_idx_i == was_pkg::CfgSeed);
    lcg_ctrl.mul  = 1'b0;
    lcg_ctrl.red  = 1'b0;
    launch_d      = 1'b0;
    fin_go        = 1'b0;
    case (state_q)
      was_pkg::StAcc:  in_if.ready  = 1'b1;
      was_pkg::StSel:  lcg_ctrl.mul = !use_max_q;
      was_pkg::StRed:  lcg_ctrl.red = 1'b1;
      was_pkg::StMul:  launch_d     = !sum_zero;
      was_pkg::StWalk: launch_d     = 1'b0;
      was_pkg::StFin:  fin_go       = out_free;
      default:         in_if.ready  = 1'b0;
    endcase
  end

  // one write strobe per cell, the cell at the current fill position
  always_comb begin
    for (int i = 0; i < MAX_ACTIONS; i++) begin
      wr_en[i] = acc_wr && (count_q == CntW'(i));
    end
  end

  // search token enters the head of the chain once the threshold is registered
  assign tok[0] = '{valid: launch_q, found: 1'b0, pos: '0, sel: '0};

  for (genvar g = 0; g < MAX_ACTIONS; g++) begin : g_cell
    was_cell #(
      .SumW (SumW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en[g]),
      .wr_data_i (sum_next),
      .rhs_i     (rhs_q),
      .count_i   (was_pkg::MaxCntW'(count_q)),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  was_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lcg_ctrl),
    .seed_i  (cfg_wdata_i[was_pkg::RngW-1:0]),
    .state_o (rng)
  );

  // selection datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == was_pkg::StMul) begin
      rhs_q <= RhsW'(draw) * RhsW'(sum_q);
    end
    case (state_q)
      was_pkg::StSel: begin
        if (use_max_q) res_q <= best_idx_q;
      end
      was_pkg::StMul: begin
        // zero sum: uniform pick scaled from the draw
        if (sum_zero) res_q <= IdxW'(zprod[ZprW-1:was_pkg::RngW]);
      end
      was_pkg::StWalk: begin
        if (tok[MAX_ACTIONS].valid) begin
          // nothing qualified: clamp to the last stored entry
          res_q <= tok[MAX_ACTIONS].found ? tok[MAX_ACTIONS].sel[IdxW-1:0]
                                          : IdxW'(count_q - CntW'(1));
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
    if (fin_go) begin
      out_action_q <= was_pkg::ActionW'(res_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= was_pkg::StAcc;
      sum_q       <= '0;
      count_q     <= '0;
      best_val_q  <= '0;
      best_idx_q  <= '0;
      use_max_q   <= 1'b0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          was_pkg::CfgUseMax: use_max_q <= cfg_wdata_i[0];
          default:            use_max_q <= use_max_q;
        endcase
      end
      if (fin_go) begin
        sum_q      <= '0;
        count_q    <= '0;
        best_val_q <= '0;
        best_idx_q <= '0;
      end else if (acc_wr) begin
        sum_q   <= sum_next;
        count_q <= count_q + CntW'(1);
        // strict compare keeps the lowest index on ties
        if (count_q == '0 || in_if.activation > best_val_q) begin
          best_val_q <= in_if.activation;
          best_idx_q <= IdxW'(count_q);
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid  = out_valid_q;
  assign out_if.action = out_action_q;

  // fill count never passes the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ACTIONS))
    else $error("fill count beyond chain length");

  // generator never reaches zero or the modulus
  a_rng_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rng != '0 && rng != was_pkg::LcgMod)
    else $error("generator state out of range");

  // a last word always starts a selection
  a_last_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_if.last |=> state_q == was_pkg::StSel)
    else $error("last word did not start selection");

  // a result only appears out of the final state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == was_pkg::StFin))
    else $error("result loaded outside final state");

  // the token is launched only for a nonzero sum
  a_launch_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> !sum_zero && state_q == was_pkg::StWalk)
    else $error("search token launched without a weighted draw");

endmodule

[verif/weighted_action_selector_tb.sv]
// predicted actions and the block state they are computed from
class action_scoreboard;
  logic [19:0] prefix_sum [was_pkg::DefMaxActions];
  logic [19:0] total;
  logic [4:0]  count;
  logic [15:0] peak;
  logic [3:0]  peak_idx;
  logic [30:0] gen_state;
  bit          argmax_mode;
  logic [3:0]  expected_actions [$];
  int          errors;

  function new();
    int i;
    for (i = 0; i < was_pkg::DefMaxActions; i++) prefix_sum[i] = '0;
    clear_set();
    argmax_mode = 1'b0;
    gen_state   = 31'd1;
    errors      = 0;
  endfunction

  function void clear_set();
    total    = '0;
    count    = '0;
    peak     = '0;
    peak_idx = '0;
  endfunction

  function int pending();
    return expected_actions.size();
  endfunction

  function void write_reg(logic [was_pkg::CfgIdxW-1:0] idx,
                          logic [was_pkg::CfgDataW-1:0] val);
    case (idx)
      was_pkg::CfgUseMax: argmax_mode = val[0];
      was_pkg::CfgSeed: begin
        // zero and the modulus would stall the generator
        if (val == '0 || val == was_pkg::LcgMod) gen_state = 31'd1;
        else gen_state = val;
      end
      default: ;
    endcase
  endfunction

  // advance the generator once and return the draw r = x - 1
  function logic [63:0] step_generator();
    logic [63:0] prod;
    prod = 64'(gen_state) * 64'(was_pkg::LcgMul);
    prod = prod % 64'(was_pkg::LcgMod);
    gen_state = prod[30:0];
    if (gen_state == '0) gen_state = 31'd1;
    return 64'(gen_state) - 64'd1;
  endfunction

  function void note_word(logic [15:0] act, logic lst);
    logic [63:0] r;
    logic [63:0] rhs;
    logic [63:0] scaled;
    logic [3:0]  pick;
    bit          found;
    int          n;
    int          i;
    if (count < was_pkg::DefMaxActions) begin
      total = total + 20'(act);
      prefix_sum[count] = total;
      if (count == '0 || act > peak) begin
        peak     = act;
        peak_idx = count[3:0];
      end
      count = count + 5'd1;
    end
    if (!lst) return;
    n = int'(count);
    if (argmax_mode) begin
      pick = peak_idx;
    end else begin
      r = step_generator();
      if (total != '0) begin
        rhs   = r * 64'(total);
        pick  = 4'(n - 1);
        found = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!found && ((64'(prefix_sum[i]) << 31) >= rhs)) begin
            pick  = 4'(i);
            found = 1'b1;
          end
        end
      end else begin
        scaled = (r * 64'(n)) >> 31;
        if (scaled >= 64'(n)) scaled = 64'(n - 1);
        pick = scaled[3:0];
      end
    end
    expected_actions.push_back(pick);
    clear_set();
  endfunction

  function void check_action(logic [3:0] got);
    logic [3:0] want;
    if (expected_actions.size() == 0) begin
      $error("action: expected none, actual %0d", got);
      errors++;
    end else begin
      want = expected_actions.pop_front();
      if (got !== want) begin
        $error("action: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction
endclass

module weighted_action_selector_tb;

  localparam int unsigned MaxActions = was_pkg::DefMaxActions;
  // longest set walk plus margin, used before config writes and at the end
  localparam int SettleCycles = 2 * (MaxActions + 5) + 8;
  localparam int TotalItems = 1500;
  // random words left for the part of the run without idling
  localparam int CalmItems = 200;
  // receiver hold-off long enough to fill the block and stall its input
  localparam int LongHold = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                         cfg_we_i;
  logic [was_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [was_pkg::CfgDataW-1:0] cfg_wdata_i;

  was_in_if  in_if ();
  was_out_if out_if ();

  action_scoreboard sb;

  int items_sent;
  // no idling on either side once set
  bit calm;
  // asks the receiver for one long hold-off
  bit long_hold_req;

  always #1 clk_i = ~clk_i;

  weighted_action_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // monitor: every value read here was settled before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_if.valid && in_if.ready) sb.note_word(in_if.activation, in_if.last);
      if (out_if.valid && out_if.ready) sb.check_action(out_if.action);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
      end else if (hold_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 16);
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one word and wait for the handshake; valid stays high when the
  // next word follows without a gap
  task automatic push_word(input logic [15:0] act, input logic lst);
    in_if.valid      <= 1'b1;
    in_if.activation <= act;
    in_if.last       <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // stop offering, wait for every predicted action, then let the walk finish
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [was_pkg::CfgIdxW-1:0] idx,
                         input logic [was_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one set of random length and content, sometimes past the store depth
  task automatic random_set();
    int len;
    int kind;
    int i;
    logic [15:0] act;
    kind = $urandom_range(0, 19);
    if (kind == 0) len = $urandom_range(MaxActions + 1, MaxActions + 4);
    else if (kind < 4) len = $urandom_range(1, 3);
    else len = $urandom_range(1, MaxActions);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: act = 16'h0000;
        1: act = 16'hFFFF;
        2: act = 16'($urandom_range(0, 15));
        default: act = 16'($urandom);
      endcase
      // an all-zero set exercises the zero-sum pick
      if (kind == 1) act = 16'h0000;
      push_word(act, (i == len - 1));
    end
  endtask

  // seeds lean on the edges of the generator range
  function automatic logic [was_pkg::CfgDataW-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'd1;
      3: return 31'h7FFF_FFFE;
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    int ph;
    int nsets;
    int s;
    int i;
    logic [15:0] act;
    sb = new();
    items_sent    = 0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.activation <= '0;
    in_if.last       <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_wdata_i      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sampling mode from reset: single full-scale word
    push_word(16'hFFFF, 1'b1);
    // zero-sum set
    push_word(16'h0000, 1'b0);
    push_word(16'h0000, 1'b1);
    // zero first prefix, full-scale, smallest nonzero
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h0001, 1'b1);
    settle();

    // max mode over an overfull set: tie on the max goes to the lower index,
    // the dropped word carries a larger value and the last flag
    set_reg(was_pkg::CfgUseMax, 31'd1);
    for (i = 0; i <= MaxActions; i++) begin
      if (i == 1 || i == 3) act = 16'hFFFE;
      else if (i == MaxActions) act = 16'hFFFF;
      else act = 16'(i * 4099);
      push_word(act, (i == MaxActions));
    end
    settle();

    // out-of-range seeds fall back to one
    set_reg(was_pkg::CfgUseMax, 31'h7FFF_FFFE);
    set_reg(was_pkg::CfgSeed, 31'd0);
    push_word(16'h8000, 1'b1);
    settle();
    set_reg(was_pkg::CfgSeed, 31'h7FFF_FFFF);
    push_word(16'h0001, 1'b1);
    settle();

    // random phases, each under one register setting
    ph = 0;
    while (items_sent < TotalItems) begin
      set_reg(was_pkg::CfgUseMax, 31'($urandom));
      if ($urandom_range(0, 2) != 0) set_reg(was_pkg::CfgSeed, pick_seed());
      // one long receiver hold-off while words keep coming
      if (ph == 3) long_hold_req = 1'b1;
      nsets = (ph == 3) ? 12 : $urandom_range(4, 12);
      for (s = 0; s < nsets; s++) begin
        if (items_sent >= TotalItems - CalmItems) calm = 1'b1;
        random_set();
        // sender pause halfway through a phase until every action is back
        if (ph == 6 && s == nsets / 2) settle();
      end
      settle();
      ph++;
    end

    if (sb.errors == 0) begin
      $display("weighted_action_selector: match");
    end else begin
      $display("weighted_action_selector: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("weighted_action_selector: mismatch");
    $finish;
  end

endmodule
